// ===== rtl/core/random_frame_polarization_rotate_defines.svh =====
// Assertion macros shared by the checker of the random frame rotation block.
// Depends on nothing; the asserting module must provide clk and rst.
`ifndef RANDOM_FRAME_POLARIZATION_ROTATE_DEFINES_SVH
`define RANDOM_FRAME_POLARIZATION_ROTATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RFPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rfpr_pkg.sv =====
// Package of the random frame rotation block: payload types, register
// indexes, fixed-point constants and rounding helpers. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rfpr_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int TRIG_BITS     = 28;
  localparam int ALIGN_BITS    = 12;
  localparam int GUARD_BITS    = 8;
  localparam int ANGLE_BITS    = 13;
  localparam int N_ANGLES      = 4;
  localparam int N_TERMS       = 40;
  localparam int N_VECTORS_DEF = 4;

  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [15:0] ONE16 = 16'(ONE64);

  localparam logic [2:0] REG_ALIGN       = 3'd0;
  localparam logic [2:0] REG_ANGLE_ONE   = 3'd1;
  localparam logic [2:0] REG_ANGLE_TWO   = 3'd2;
  localparam logic [2:0] REG_ANGLE_THREE = 3'd3;
  localparam logic [2:0] REG_ANGLE_FOUR  = 3'd4;

  typedef struct packed {
    logic signed [15:0] zdir_x;
    logic signed [15:0] zdir_y;
    logic signed [15:0] zdir_z;
    logic signed [15:0] xdir_x;
    logic signed [15:0] xdir_y;
    logic signed [15:0] xdir_z;
  } item_t;

  typedef struct packed {
    logic [1:0]         vector_index;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               last;
    logic               degenerate;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [27:0] den;
    logic [5:0]  qbits;
  } div_req_t;

  // Shift right with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] sround(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat_one(input logic signed [63:0] v);
    if (v > ONE64) return ONE16;
    if (v < -ONE64) return -ONE16;
    return 16'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rfpr_div.sv =====
// Bit-serial restoring divider with a selectable quotient length.
// Depends on rfpr_pkg for the request struct.
`timescale 1ns / 1ps
`default_nettype none

module rfpr_div import rfpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire div_req_t    req,
  output logic             done,
  output logic [35:0]      quot
);

  logic [47:0] rem;
  logic [47:0] dsh;
  logic [5:0]  cnt;
  logic        run;
  logic        ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        cnt  <= req.qbits;
        rem  <= req.num;
        dsh  <= 48'(req.den) << (req.qbits - 6'd1);
        quot <= '0;
      end else if (run) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quot <= {quot[34:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rfpr_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on rfpr_pkg only by convention of the project.
`timescale 1ns / 1ps
`default_nettype none

module rfpr_sqrt import rfpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [55:0] radicand,
  output logic             done,
  output logic [27:0]      root
);

  logic [55:0] num;
  logic [55:0] res;
  logic [55:0] bitv;
  logic        run;
  logic [55:0] trial;

  assign trial = res + bitv;
  assign root  = res[27:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        num  <= radicand;
        res  <= '0;
        bitv <= 56'd1 << 54;
      end else if (run) begin
        if (num >= trial) begin
          num <= num - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 56'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/random_frame_polarization_rotate.sv =====
// Top level of the random frame rotation block: sequencer, shared multiplier
// and vector store. Depends on rfpr_pkg, rfpr_div and rfpr_sqrt.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low. From the two random
// directions it builds the molecular frame (z axis c, x axis a, y axis b) and
// emits one result per stored polarization vector, each shown for exactly one
// cycle with result_strobe high; the receiver cannot stall, so it must take
// every strobed result. Two square roots and six divisions on the shared
// bit-serial units dominate the work of an item, and each vector then runs
// through the single shared multiplier. When an axis has zero length the
// results come one per cycle, all zero, with degenerate set. Writing an angle
// register recomputes its sine and cosine with a 40-term series that runs
// through the same multiplier and divider, and busy stays high meanwhile.
// cfg_ready is high only while the block is idle and start is low.

module random_frame_polarization_rotate import rfpr_pkg::*; #(
  parameter int N_VECTORS = N_VECTORS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             result_strobe,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Only as many vectors are stored as there are angle registers to fill them.
  localparam int N_STORE = (N_VECTORS < N_ANGLES) ? N_VECTORS : N_ANGLES;
  localparam int VIW     = (N_STORE > 1) ? $clog2(N_STORE) : 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CZ_M = 5'd1;
  localparam logic [4:0] S_CZ_W = 5'd2;
  localparam logic [4:0] S_N2_M = 5'd3;
  localparam logic [4:0] S_N2_A = 5'd4;
  localparam logic [4:0] S_SQ_GO = 5'd5;
  localparam logic [4:0] S_SQ_W = 5'd6;
  localparam logic [4:0] S_DV_GO = 5'd7;
  localparam logic [4:0] S_DV_W = 5'd8;
  localparam logic [4:0] S_PJ_M = 5'd9;
  localparam logic [4:0] S_PJ_A = 5'd10;
  localparam logic [4:0] S_PJ_W = 5'd11;
  localparam logic [4:0] S_RC_M = 5'd12;
  localparam logic [4:0] S_RC_W = 5'd13;
  localparam logic [4:0] S_X_M0 = 5'd14;
  localparam logic [4:0] S_X_M1 = 5'd15;
  localparam logic [4:0] S_X_W = 5'd16;
  localparam logic [4:0] S_R_M0 = 5'd17;
  localparam logic [4:0] S_R_M1 = 5'd18;
  localparam logic [4:0] S_R_W = 5'd19;
  localparam logic [4:0] S_DG_OUT = 5'd20;
  localparam logic [4:0] S_TG_ADD = 5'd21;
  localparam logic [4:0] S_TG_M = 5'd22;
  localparam logic [4:0] S_TG_DV = 5'd23;
  localparam logic [4:0] S_TG_DW = 5'd24;
  localparam logic [4:0] S_TG_FIN = 5'd25;

  logic [4:0]          state;
  logic [1:0]          k;
  logic                ph;
  logic [VIW-1:0]      vi;
  logic [VIW-1:0]      tk;

  // Working vector: first the scaled z direction, later the residual r.
  logic signed [20:0]  vr [3];
  logic signed [15:0]  xv [3];
  logic signed [15:0]  axis_a [3];
  logic signed [15:0]  axis_b [3];
  logic signed [15:0]  axis_c [3];
  logic signed [15:0]  rot [2];
  logic signed [15:0]  sin_q [N_STORE];
  logic signed [15:0]  cos_q [N_STORE];

  logic [39:0]         n2;
  logic [27:0]         sroot;
  logic signed [39:0]  acc;
  logic signed [17:0]  p;
  logic [15:0]         align;

  // Series state for the sine and cosine of one angle.
  logic signed [15:0]  ang;
  logic signed [35:0]  t;
  logic signed [37:0]  sacc;
  logic signed [37:0]  cacc;
  logic [5:0]          n;
  logic                tneg;

  // Shared multiplier, registered product.
  logic signed [35:0]  mul_a;
  logic signed [23:0]  mul_b;
  logic signed [59:0]  prod;

  div_req_t            dreq;
  logic                div_done;
  logic [35:0]         quot;
  logic                sq_start;
  logic                sq_done;
  logic [27:0]         sq_root;

  logic [1:0]          j1;
  logic [1:0]          j2;
  logic signed [15:0]  row1;
  logic signed [15:0]  row2;
  logic signed [63:0]  tp;
  logic [63:0]         tp_mag;
  logic [20:0]         v_mag;
  logic [6:0]          n1;
  logic signed [15:0]  unorm;
  logic signed [15:0]  dot_sum;
  logic signed [15:0]  cross_v;
  logic                vi_last;

  assign busy      = state != S_IDLE;
  assign cfg_ready = (state == S_IDLE) && !start;
  assign vi_last   = int'(vi) == N_STORE - 1;

  // Cyclic neighbours of the current component for the cross product, and the axis rows for the rotation.
  always_comb begin
    case (k)
      2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
      2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
      default: begin j1 = 2'd0; j2 = 2'd1; end
    endcase
    case (k)
      2'd0:    begin row1 = axis_a[1]; row2 = axis_a[2]; end
      2'd1:    begin row1 = axis_b[1]; row2 = axis_b[2]; end
      default: begin row1 = axis_c[1]; row2 = axis_c[2]; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CZ_M: begin mul_a = 36'(vr[2]); mul_b = 24'($signed({1'b0, align})); end
      S_N2_M: begin mul_a = 36'(vr[k]); mul_b = 24'(vr[k]); end
      S_PJ_M: begin mul_a = 36'(xv[k]); mul_b = 24'(axis_c[k]); end
      S_RC_M: begin mul_a = 36'(p); mul_b = 24'(axis_c[k]); end
      S_X_M0: begin mul_a = 36'(axis_c[j1]); mul_b = 24'(axis_a[j2]); end
      S_X_M1: begin mul_a = 36'(axis_c[j2]); mul_b = 24'(axis_a[j1]); end
      S_R_M0: begin mul_a = 36'(row1); mul_b = 24'(sin_q[vi]); end
      S_R_M1: begin mul_a = 36'(row2); mul_b = 24'(cos_q[vi]); end
      S_TG_M: begin mul_a = t; mul_b = 24'(ang); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Requests for the shared divider and the square-root unit. The term times
  // the raw Q2.13 angle drops the angle's fraction bits to stay at term scale.
  always_comb begin
    tp     = sround(64'(prod), ANGLE_BITS);
    tp_mag = tp[63] ? 64'(-tp) : 64'(tp);
    v_mag  = vr[k][20] ? 21'(-vr[k]) : 21'(vr[k]);
    n1     = 7'(n) + 7'd1;
    dreq   = '0;
    if (state == S_DV_GO) begin
      dreq.start = 1'b1;
      dreq.num   = (48'(v_mag) << (FRAC_BITS + GUARD_BITS)) + 48'(sroot >> 1);
      dreq.den   = sroot;
      dreq.qbits = 6'd16;
    end else if (state == S_TG_DV) begin
      dreq.start = 1'b1;
      dreq.num   = 48'(tp_mag) + 48'(n1 >> 1);
      dreq.den   = 28'(n1);
      dreq.qbits = 6'd36;
    end
    sq_start = (state == S_SQ_GO) && (n2 != '0);
  end

  always_comb begin
    unorm   = sat_one(vr[k][20] ? -$signed(64'(quot)) : $signed(64'(quot)));
    dot_sum = sat_one(sround(64'(acc) + 64'(prod), FRAC_BITS));
    cross_v = sat_one(sround(64'(acc) - 64'(prod), FRAC_BITS));
  end

  rfpr_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quot (quot)
  );

  rfpr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({n2, 16'd0}),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      align         <= 16'd4096;
      for (int i = 0; i < N_STORE; i++) begin
        sin_q[i] <= '0;
        cos_q[i] <= ONE16;
      end
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            vr[0] <= 21'(item.zdir_x);
            vr[1] <= 21'(item.zdir_y);
            vr[2] <= 21'(item.zdir_z);
            xv[0] <= item.xdir_x;
            xv[1] <= item.xdir_y;
            xv[2] <= item.xdir_z;
            state <= S_CZ_M;
          end else if (cfg_valid) begin
            case (cfg_index)
              REG_ALIGN: align <= cfg_data;
              default: begin
                if (cfg_index inside {REG_ANGLE_ONE, REG_ANGLE_TWO, REG_ANGLE_THREE,
                                      REG_ANGLE_FOUR}
                    && int'(cfg_index - REG_ANGLE_ONE) < N_STORE) begin
                  ang   <= $signed(cfg_data);
                  tk    <= VIW'(cfg_index - REG_ANGLE_ONE);
                  t     <= 36'sd1 <<< TRIG_BITS;
                  sacc  <= '0;
                  cacc  <= '0;
                  n     <= '0;
                  state <= S_TG_ADD;
                end
              end
            endcase
          end
        end
        S_CZ_M: state <= S_CZ_W;
        S_CZ_W: begin
          vr[2] <= 21'(sround(64'(prod), ALIGN_BITS));
          k     <= '0;
          n2    <= '0;
          ph    <= 1'b0;
          state <= S_N2_M;
        end
        S_N2_M: state <= S_N2_A;
        S_N2_A: begin
          n2 <= n2 + 40'(prod);
          if (k == 2'd2) begin
            state <= S_SQ_GO;
          end else begin
            k     <= k + 2'd1;
            state <= S_N2_M;
          end
        end
        S_SQ_GO: begin
          vi    <= '0;
          state <= (n2 == '0) ? S_DG_OUT : S_SQ_W;
        end
        S_SQ_W: begin
          if (sq_done) begin
            sroot <= sq_root;
            k     <= '0;
            state <= S_DV_GO;
          end
        end
        S_DV_GO: state <= S_DV_W;
        S_DV_W: begin
          if (div_done) begin
            if (ph) begin
              axis_a[k] <= unorm;
            end else begin
              axis_c[k] <= unorm;
            end
            if (k == 2'd2) begin
              k     <= '0;
              acc   <= '0;
              state <= ph ? S_X_M0 : S_PJ_M;
            end else begin
              k     <= k + 2'd1;
              state <= S_DV_GO;
            end
          end
        end
        S_PJ_M: state <= S_PJ_A;
        S_PJ_A: begin
          acc <= acc + 40'(prod);
          if (k == 2'd2) begin
            state <= S_PJ_W;
          end else begin
            k     <= k + 2'd1;
            state <= S_PJ_M;
          end
        end
        S_PJ_W: begin
          p     <= 18'(sround(64'(acc), FRAC_BITS));
          k     <= '0;
          state <= S_RC_M;
        end
        S_RC_M: state <= S_RC_W;
        S_RC_W: begin
          vr[k] <= 21'(xv[k]) - 21'(sround(64'(prod), FRAC_BITS));
          if (k == 2'd2) begin
            k     <= '0;
            n2    <= '0;
            ph    <= 1'b1;
            state <= S_N2_M;
          end else begin
            k     <= k + 2'd1;
            state <= S_RC_M;
          end
        end
        S_X_M0: state <= S_X_M1;
        S_X_M1: begin
          acc   <= 40'(prod);
          state <= S_X_W;
        end
        S_X_W: begin
          axis_b[k] <= cross_v;
          if (k == 2'd2) begin
            k     <= '0;
            vi    <= '0;
            state <= S_R_M0;
          end else begin
            k     <= k + 2'd1;
            state <= S_X_M0;
          end
        end
        S_R_M0: state <= S_R_M1;
        S_R_M1: begin
          acc   <= 40'(prod);
          state <= S_R_W;
        end
        S_R_W: begin
          if (k == 2'd2) begin
            result_strobe       <= 1'b1;
            result.vector_index <= 2'(vi);
            result.rot_x        <= rot[0];
            result.rot_y        <= rot[1];
            result.rot_z        <= dot_sum;
            result.last         <= vi_last;
            result.degenerate   <= 1'b0;
            k                   <= '0;
            vi                  <= vi + VIW'(1);
            state               <= vi_last ? S_IDLE : S_R_M0;
          end else begin
            rot[k[0]] <= dot_sum;
            k         <= k + 2'd1;
            state     <= S_R_M0;
          end
        end
        S_DG_OUT: begin
          result_strobe       <= 1'b1;
          result.vector_index <= 2'(vi);
          result.rot_x        <= '0;
          result.rot_y        <= '0;
          result.rot_z        <= '0;
          result.last         <= vi_last;
          result.degenerate   <= 1'b1;
          vi                  <= vi + VIW'(1);
          if (vi_last) begin
            state <= S_IDLE;
          end
        end
        S_TG_ADD: begin
          case (n[1:0])
            2'd0:    cacc <= cacc + 38'(t);
            2'd1:    sacc <= sacc + 38'(t);
            2'd2:    cacc <= cacc - 38'(t);
            default: sacc <= sacc - 38'(t);
          endcase
          state <= (int'(n) == N_TERMS - 1) ? S_TG_FIN : S_TG_M;
        end
        S_TG_M: state <= S_TG_DV;
        S_TG_DV: begin
          tneg  <= tp[63];
          state <= S_TG_DW;
        end
        S_TG_DW: begin
          if (div_done) begin
            t     <= tneg ? -$signed(quot) : $signed(quot);
            n     <= n + 6'd1;
            state <= S_TG_ADD;
          end
        end
        S_TG_FIN: begin
          sin_q[tk] <= sat_one(sround(64'(sacc), TRIG_BITS - FRAC_BITS));
          cos_q[tk] <= sat_one(sround(64'(cacc), TRIG_BITS - FRAC_BITS));
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rfpr_checker.sv =====
// Port-level checker for the random frame rotation block, bound to the top.
// Depends on rfpr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "random_frame_polarization_rotate_defines.svh"

module rfpr_checker import rfpr_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    result_strobe,
  input wire result_t result
);

  // A result that is not the last of its item is produced mid-run.
  `RFPR_ASSERT_IMP(a_mid_busy, result_strobe && !result.last, busy, "result outside a run")

  // An accepted item starts a run.
  `RFPR_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not start a run")

  // Nothing follows the last result of an item in the next cycle.
  `RFPR_ASSERT_NXT(a_last_gap, result_strobe && result.last, !result_strobe, "result after last")

  // A degenerate frame gives zero components.
  `RFPR_ASSERT_IMP(a_deg_zero, result_strobe && result.degenerate,
    result.rot_x == 16'sd0 && result.rot_y == 16'sd0 && result.rot_z == 16'sd0,
    "degenerate result not zero")

endmodule

bind random_frame_polarization_rotate rfpr_checker u_rfpr_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for random_frame_polarization_rotate: directed and
// random frame items, register sweeps, and a bit-exact predictor of each result.
// Depends on rfpr_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
  import rfpr_pkg::*;

  // Register indexes past the last angle register; writes there are dropped.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int VECS_PER_ITEM = (N_VECTORS_DEF < N_ANGLES) ? N_VECTORS_DEF : N_ANGLES;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        result_strobe;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  random_frame_polarization_rotate uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_strobe(result_strobe), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Shadow copy of the block's registers and of its sine/cosine store.
  logic [15:0]        align_shadow;
  logic [15:0]        angle_shadow [N_ANGLES];
  logic signed [15:0] pol_sin [N_ANGLES];
  logic signed [15:0] pol_cos [N_ANGLES];

  // Results the block still owes us, oldest first.
  result_t pending_results [$];
  int      mismatch_count;
  longint  cycle_count;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers. All rounding is to nearest with ties away from zero.
  // ---------------------------------------------------------------------------
  function automatic longint rshift_rnd(longint v, int s);
    longint unsigned m;
    if (s == 0) return v;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_rnd(longint v, longint d);
    longint unsigned m;
    if (d <= 0) return 0;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m + longint'(d) / 2) / longint'(d);
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Unit vector of v; returns 0 when v has zero length.
  function automatic bit unit_vector(input longint v [3], output longint u [3]);
    longint unsigned len_sq, len;
    len_sq = 0;
    for (int i = 0; i < 3; i++) len_sq += longint'(v[i] * v[i]);
    u = '{0, 0, 0};
    if (len_sq == 0) return 1'b0;
    len = int_sqrt(len_sq << 16);
    for (int i = 0; i < 3; i++)
      u[i] = clamp_unit(div_rnd(v[i] * (longint'(1) << (FRAC_BITS + GUARD_BITS)),
                                longint'(len)));
    return 1'b1;
  endfunction

  // Taylor series for the sine and cosine of one angle register, Q2.13 input.
  task automatic refresh_polarization(int k);
    longint x, term, sin_acc, cos_acc;
    x = longint'($signed(angle_shadow[k])) * (longint'(1) << (TRIG_BITS - ANGLE_BITS));
    term = longint'(1) << TRIG_BITS;
    sin_acc = 0;
    cos_acc = 0;
    for (int n = 0; n < N_TERMS; n++) begin
      case (n % 4)
        0: cos_acc += term;
        1: sin_acc += term;
        2: cos_acc -= term;
        default: sin_acc -= term;
      endcase
      term = div_rnd(rshift_rnd(term * x, TRIG_BITS), n + 1);
    end
    pol_sin[k] = 16'(clamp_unit(rshift_rnd(sin_acc, TRIG_BITS - FRAC_BITS)));
    pol_cos[k] = 16'(clamp_unit(rshift_rnd(cos_acc, TRIG_BITS - FRAC_BITS)));
  endtask

  // Builds the molecular frame of one item and queues the rotated vectors.
  task automatic queue_rotated_vectors(item_t it);
    longint zv [3], xv [3], r [3], ax_c [3], ax_a [3], ax_b [3];
    longint proj, sn, cs;
    bit ok;
    result_t res;
    zv[0] = it.zdir_x;
    zv[1] = it.zdir_y;
    zv[2] = rshift_rnd(longint'(it.zdir_z) * longint'(align_shadow), ALIGN_BITS);
    xv[0] = it.xdir_x;
    xv[1] = it.xdir_y;
    xv[2] = it.xdir_z;
    ax_a = '{0, 0, 0};
    ax_b = '{0, 0, 0};
    ok = unit_vector(zv, ax_c);
    if (ok) begin
      proj = rshift_rnd(xv[0] * ax_c[0] + xv[1] * ax_c[1] + xv[2] * ax_c[2], FRAC_BITS);
      for (int i = 0; i < 3; i++) r[i] = xv[i] - rshift_rnd(proj * ax_c[i], FRAC_BITS);
      ok = unit_vector(r, ax_a);
    end
    if (ok) begin
      ax_b[0] = clamp_unit(rshift_rnd(ax_c[1] * ax_a[2] - ax_c[2] * ax_a[1], FRAC_BITS));
      ax_b[1] = clamp_unit(rshift_rnd(ax_c[2] * ax_a[0] - ax_c[0] * ax_a[2], FRAC_BITS));
      ax_b[2] = clamp_unit(rshift_rnd(ax_c[0] * ax_a[1] - ax_c[1] * ax_a[0], FRAC_BITS));
    end
    for (int k = 0; k < VECS_PER_ITEM; k++) begin
      sn = pol_sin[k];
      cs = pol_cos[k];
      res.vector_index = 2'(k);
      res.rot_x = ok ? 16'(clamp_unit(rshift_rnd(ax_a[1] * sn + ax_a[2] * cs, FRAC_BITS))) : '0;
      res.rot_y = ok ? 16'(clamp_unit(rshift_rnd(ax_b[1] * sn + ax_b[2] * cs, FRAC_BITS))) : '0;
      res.rot_z = ok ? 16'(clamp_unit(rshift_rnd(ax_c[1] * sn + ax_c[2] * cs, FRAC_BITS))) : '0;
      res.last = (k == VECS_PER_ITEM - 1);
      res.degenerate = !ok;
      pending_results.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving. Everything changes with nonblocking assignments at the rising edge.
  // ---------------------------------------------------------------------------

  // One item transfer. When more items follow, start may stay high straight
  // into the next call; otherwise it is dropped right after the transfer.
  task automatic send_item(item_t it, bit more);
    int gap;
    if (!start) start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    queue_rotated_vectors(it);
    gap = $urandom_range(6);
    if (!more || gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until the block has delivered every result we expect.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register writes only happen once the block is idle and start is low.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ALIGN) begin
      align_shadow = data;
    end else if (idx <= REG_ANGLE_FOUR) begin
      angle_shadow[idx - 1] = data;
      refresh_polarization(idx - 1);
    end
  endtask

  function automatic logic signed [15:0] in_range_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // Mostly well-formed directions, some raw 16-bit noise, a few degenerate frames.
  function automatic item_t random_item();
    item_t it;
    int pick;
    int unsigned scale;
    pick = $urandom_range(99);
    it.zdir_x = in_range_comp();
    it.zdir_y = in_range_comp();
    it.zdir_z = in_range_comp();
    it.xdir_x = in_range_comp();
    it.xdir_y = in_range_comp();
    it.xdir_z = in_range_comp();
    if (pick < 10) begin
      it = item_t'({$urandom, $urandom, $urandom});
    end else if (pick < 15) begin
      // Small magnitudes stress the rounding of the normalizer.
      it.zdir_x = 16'($signed($urandom_range(8)) - 4);
      it.zdir_y = 16'($signed($urandom_range(8)) - 4);
      it.zdir_z = 16'($signed($urandom_range(8)) - 4);
    end else if (pick < 19) begin
      // X along Z (isotropic only along z): the x axis may collapse.
      scale = $urandom_range(4) + 1;
      it.zdir_x = 0;
      it.zdir_y = 0;
      it.xdir_x = 0;
      it.xdir_y = 0;
      it.xdir_z = 16'(int'(it.zdir_z) / int'(scale));
    end else if (pick < 21) begin
      it.zdir_x = 0;
      it.zdir_y = 0;
      it.zdir_z = 0;
    end
    return it;
  endfunction

  task automatic send_random_items(int count);
    for (int n = 0; n < count; n++) send_item(random_item(), n != count - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the fields and each special case, under reset settings.
  task automatic test_directed_frames();
    item_t cases [$];
    cases.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0});
    cases.push_back('{-16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384,
                      16'sd16384});
    cases.push_back('{16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384,
                      -16'sd16384});
    // Zero-length z axis.
    cases.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd200, 16'sd300});
    // X parallel to Z: zero-length x axis.
    cases.push_back('{16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd500});
    // X all zero.
    cases.push_back('{16'sd3, 16'sd4, 16'sd5, 16'sd0, 16'sd0, 16'sd0});
    // Raw 16-bit extremes, outside the nominal range.
    cases.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                      16'sd32767});
    cases.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                      -16'sd32768});
    cases.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0});
    cases.push_back('{-16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd0});
    cases.push_back('{16'sd12345, -16'sd7, 16'sd9, -16'sd16384, 16'sd16383, 16'sd1});
    foreach (cases[i]) send_item(cases[i], i != cases.size() - 1);
  endtask

  // Walks each register through its extremes and a random value.
  task automatic test_register_sweep();
    logic [15:0] aligns [4];
    logic [15:0] angles [6];
    aligns = '{16'd0, 16'd65535, 16'd4096, 16'($urandom)};
    angles = '{16'(-25736), 16'(25736), 16'h8000, 16'h7FFF,
               16'($signed($urandom_range(51472)) - 25736), 16'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_ALIGN, aligns[p % 4]);
      write_reg(REG_ANGLE_ONE,   angles[p]);
      write_reg(REG_ANGLE_TWO,   angles[(p + 1) % 6]);
      write_reg(REG_ANGLE_THREE, angles[(p + 2) % 6]);
      write_reg(REG_ANGLE_FOUR,  angles[(p + 3) % 6]);
      // Align zero flattens every z axis onto the xy plane.
      if (aligns[p % 4] == 16'd0)
        send_item('{16'sd0, 16'sd0, 16'sd16384, 16'sd1, 16'sd2, 16'sd3}, 1'b1);
      send_random_items(24);
    end
  endtask

  // Writes to unused indexes must leave every register alone.
  task automatic test_unused_index();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h1234);
    send_random_items(10);
  endtask

  // Long random run at mixed settings; the sender drains once in the middle.
  task automatic test_random_frames();
    write_reg(REG_ALIGN, 16'($urandom_range(12000)));
    write_reg(REG_ANGLE_TWO, 16'($signed($urandom_range(51472)) - 25736));
    send_random_items(120);
    wait_drained();
    send_random_items(120);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed result must match the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: vector_index %0d", result.vector_index);
        mismatch_count++;
      end else begin
        result_t exp_res;
        exp_res = pending_results.pop_front();
        if (result.vector_index !== exp_res.vector_index) begin
          $error("vector_index: expected %0d, got %0d", exp_res.vector_index,
                 result.vector_index);
          mismatch_count++;
        end
        if (result.rot_x !== exp_res.rot_x) begin
          $error("rot_x: expected %0d, got %0d", exp_res.rot_x, result.rot_x);
          mismatch_count++;
        end
        if (result.rot_y !== exp_res.rot_y) begin
          $error("rot_y: expected %0d, got %0d", exp_res.rot_y, result.rot_y);
          mismatch_count++;
        end
        if (result.rot_z !== exp_res.rot_z) begin
          $error("rot_z: expected %0d, got %0d", exp_res.rot_z, result.rot_z);
          mismatch_count++;
        end
        if (result.last !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, result.last);
          mismatch_count++;
        end
        if (result.degenerate !== exp_res.degenerate) begin
          $error("degenerate: expected %0d, got %0d", exp_res.degenerate,
                 result.degenerate);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: once the cycle count passes CYCLE_LIMIT, the run ends and reports
  // mismatches.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ALIGN;
    cfg_data = '0;
    // Reset state: isotropic alignment, every angle zero.
    align_shadow = 16'd4096;
    for (int k = 0; k < N_ANGLES; k++) begin
      angle_shadow[k] = '0;
      refresh_polarization(k);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_register_sweep();
    test_unused_index();
    test_random_frames();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
